/* hw/rtl/vsg_pkg.sv */
// Shared types and codes for the voice session gate.
package vsg_pkg;

  typedef enum logic [1:0] {
    ACT_WAKE  = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ARMED    = 3'd0,
    KIND_BEGIN    = 3'd1,
    KIND_AUDIO    = 3'd2,
    KIND_END      = 3'd3,
    KIND_FEEDBACK = 3'd4
  } kind_t;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_LENGTH  = 2'd1;
  localparam logic [1:0] CAUSE_SILENCE = 2'd2;

  localparam logic [1:0] NOTE_NONE     = 2'd0;
  localparam logic [1:0] NOTE_DETECTOR = 2'd1;
  localparam logic [1:0] NOTE_NO_ROUTE = 2'd2;

  typedef enum logic [2:0] {
    REG_DETECTOR_READY    = 3'd0,
    REG_REMOTE_ROUTE_UP   = 3'd1,
    REG_LOCAL_ROUTE_UP    = 3'd2,
    REG_SAMPLE_LIMIT      = 3'd3,
    REG_DURATION_LIMIT_MS = 3'd4,
    REG_SILENCE_LIMIT_MS  = 3'd5
  } reg_index_t;

  localparam logic [31:0] SAMPLE_LIMIT_RESET   = 32'd160000;
  localparam logic [31:0] DURATION_LIMIT_RESET = 32'd10000;
  localparam logic [31:0] SILENCE_LIMIT_RESET  = 32'd800;
  localparam logic [31:0] FIRST_SESSION        = 32'd1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ARMED  = 3'b010,
    PH_LISTEN = 3'b100
  } phase_t;

  typedef struct packed {
    logic        detector_ready;
    logic        remote_route_up;
    logic        local_route_up;
    logic [31:0] sample_limit;
    logic [31:0] duration_limit_ms;
    logic [31:0] silence_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_ms;
    logic        speech_seen;
    logic [15:0] frame_samples;
  } evt_t;

endpackage

/* hw/rtl/vsg_in_if.sv */
// Event channel: valid/ready handshake carrying one input word.
interface vsg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] time_ms;
  logic        speech_seen;
  logic [15:0] frame_samples;

  modport source (output valid, action, time_ms, speech_seen, frame_samples, input ready);
  modport sink (input valid, action, time_ms, speech_seen, frame_samples, output ready);
endinterface

/* hw/rtl/vsg_out_if.sv */
// Result channel: valid/ready handshake carrying one result word.
interface vsg_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] session_number;
  logic [31:0] sample_count;
  logic [1:0]  end_cause;
  logic [1:0]  notice;

  modport source (output valid, kind, session_number, sample_count, end_cause, notice,
                  input ready);
  modport sink (input valid, kind, session_number, sample_count, end_cause, notice,
                output ready);
endinterface

/* hw/rtl/voice_session_gate_unit.sv */
// Voice session gate top level: config registers, input stage, session core.
//
// Events (wake, audio frame, time tick) arrive as words on the evt channel
// and results leave on the res channel; both use valid/ready and move a
// word on a clock edge where valid and ready are both high. An event gives
// zero or one result word.
// Order: an accepted event is held in the input register until the core
// takes it; the session state and the result register then update together,
// and the result leaves from the result register once res is ready.
// Throughput: one event per cycle unless a result waits on res.
// Events that give no result still take one pass through the core.
// While a result waits on res, the input register can still take one more
// event; further events stall once that register is also full.
// The configuration port writes register cfg_index with cfg_data when
// cfg_we is high; write it only while no event is in flight.
// Synchronous reset empties both registers, returns to idle with session
// number 1 next, and loads the reset configuration.
module voice_session_gate_unit (
  input  logic        clk,
  input  logic        rst,
  vsg_in_if.sink      evt,
  vsg_out_if.source   res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vsg_pkg::cfg_t cfg;
  vsg_pkg::evt_t item;
  logic          item_valid;
  logic          item_take;

  vsg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vsg_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  vsg_session_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res        (res)
  );

endmodule

/* hw/rtl/vsg_cfg_regs.sv */
// Configuration register file with write-only port.
module vsg_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output vsg_pkg::cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detector_ready    <= 1'b0;
      cfg.remote_route_up   <= 1'b0;
      cfg.local_route_up    <= 1'b0;
      cfg.sample_limit      <= vsg_pkg::SAMPLE_LIMIT_RESET;
      cfg.duration_limit_ms <= vsg_pkg::DURATION_LIMIT_RESET;
      cfg.silence_limit_ms  <= vsg_pkg::SILENCE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (vsg_pkg::reg_index_t'(cfg_index))
        vsg_pkg::REG_DETECTOR_READY:    cfg.detector_ready    <= cfg_data[0];
        vsg_pkg::REG_REMOTE_ROUTE_UP:   cfg.remote_route_up   <= cfg_data[0];
        vsg_pkg::REG_LOCAL_ROUTE_UP:    cfg.local_route_up    <= cfg_data[0];
        vsg_pkg::REG_SAMPLE_LIMIT:      cfg.sample_limit      <= cfg_data;
        vsg_pkg::REG_DURATION_LIMIT_MS: cfg.duration_limit_ms <= cfg_data;
        vsg_pkg::REG_SILENCE_LIMIT_MS:  cfg.silence_limit_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/vsg_in_stage.sv */
// Input register stage holding one accepted event word.
module vsg_in_stage (
  input  logic          clk,
  input  logic          rst,
  vsg_in_if.sink        evt,
  output logic          item_valid,
  output vsg_pkg::evt_t item,
  input  logic          item_take
);

  assign evt.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      item.action        <= evt.action;
      item.time_ms       <= evt.time_ms;
      item.speech_seen   <= evt.speech_seen;
      item.frame_samples <= evt.frame_samples;
    end
  end

endmodule

/* hw/rtl/vsg_session_core.sv */
// Session state, per-event decision logic and result register.
module vsg_session_core (
  input  logic          clk,
  input  logic          rst,
  input  vsg_pkg::cfg_t cfg,
  input  logic          item_valid,
  input  vsg_pkg::evt_t item,
  output logic          item_take,
  vsg_out_if.source     res
);

  vsg_pkg::phase_t phase, phase_next;
  logic [31:0] next_session, next_session_next;
  logic [31:0] active_session, active_session_next;
  logic [31:0] listen_start_ms, listen_start_ms_next;
  logic [31:0] last_speech_ms, last_speech_ms_next;
  logic [31:0] sent_samples, sent_samples_next;

  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] out_session;
  logic [31:0] out_count;
  logic [1:0]  out_cause;
  logic [1:0]  out_notice;

  logic        emit;
  logic [2:0]  kind_next;
  logic [31:0] session_next;
  logic [31:0] count_next;
  logic [1:0]  cause_next;
  logic [1:0]  notice_next;

  logic        route;
  logic        open;
  logic [31:0] frame_n;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic [31:0] since_start;
  logic [31:0] since_speech;
  logic        length_hit;
  logic        silence_hit;

  assign item_take = item_valid && (!out_valid || res.ready);

  assign route        = cfg.remote_route_up || cfg.local_route_up;
  assign open         = (phase == vsg_pkg::PH_ARMED) || (phase == vsg_pkg::PH_LISTEN);
  assign frame_n      = {16'd0, item.frame_samples};
  assign sum          = {1'b0, sent_samples} + {1'b0, frame_n};
  assign sum_sat      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign since_start  = item.time_ms - listen_start_ms;
  assign since_speech = item.time_ms - last_speech_ms;
  assign length_hit   = (sent_samples >= cfg.sample_limit) ||
                        (since_start >= cfg.duration_limit_ms);
  assign silence_hit  = since_speech >= cfg.silence_limit_ms;

  always_comb begin
    phase_next           = phase;
    next_session_next    = next_session;
    active_session_next  = active_session;
    listen_start_ms_next = listen_start_ms;
    last_speech_ms_next  = last_speech_ms;
    sent_samples_next    = sent_samples;
    emit                 = 1'b0;
    kind_next            = vsg_pkg::KIND_FEEDBACK;
    session_next         = 32'd0;
    count_next           = 32'd0;
    cause_next           = vsg_pkg::CAUSE_NONE;
    notice_next          = vsg_pkg::NOTE_NONE;

    unique case (vsg_pkg::action_t'(item.action))
      vsg_pkg::ACT_WAKE: begin
        phase_next           = vsg_pkg::PH_IDLE;
        active_session_next  = 32'd0;
        listen_start_ms_next = 32'd0;
        last_speech_ms_next  = 32'd0;
        sent_samples_next    = 32'd0;
        emit                 = 1'b1;
        if (!cfg.detector_ready) begin
          notice_next = vsg_pkg::NOTE_DETECTOR;
        end else if (!route) begin
          notice_next = vsg_pkg::NOTE_NO_ROUTE;
        end else begin
          phase_next          = vsg_pkg::PH_ARMED;
          active_session_next = next_session;
          next_session_next   = next_session + 32'd1;
          kind_next           = vsg_pkg::KIND_ARMED;
          session_next        = next_session;
        end
      end
      vsg_pkg::ACT_FRAME, vsg_pkg::ACT_TICK: begin
        if (open && !route) begin
          // all routes gone: drop the session and report it
          phase_next           = vsg_pkg::PH_IDLE;
          active_session_next  = 32'd0;
          listen_start_ms_next = 32'd0;
          last_speech_ms_next  = 32'd0;
          sent_samples_next    = 32'd0;
          emit                 = 1'b1;
          session_next         = active_session;
          notice_next          = vsg_pkg::NOTE_NO_ROUTE;
        end else if (item.action == vsg_pkg::ACT_FRAME) begin
          if (item.speech_seen && (item.frame_samples != 16'd0)) begin
            if (phase == vsg_pkg::PH_ARMED) begin
              phase_next           = vsg_pkg::PH_LISTEN;
              listen_start_ms_next = item.time_ms;
              last_speech_ms_next  = item.time_ms;
              sent_samples_next    = frame_n;
              emit                 = 1'b1;
              kind_next            = vsg_pkg::KIND_BEGIN;
              session_next         = active_session;
              count_next           = frame_n;
            end else if (phase == vsg_pkg::PH_LISTEN) begin
              last_speech_ms_next = item.time_ms;
              sent_samples_next   = sum_sat;
              emit                = 1'b1;
              kind_next           = vsg_pkg::KIND_AUDIO;
              session_next        = active_session;
              count_next          = frame_n;
            end
          end
        end else if ((phase == vsg_pkg::PH_LISTEN) && (length_hit || silence_hit)) begin
          phase_next           = vsg_pkg::PH_IDLE;
          active_session_next  = 32'd0;
          listen_start_ms_next = 32'd0;
          last_speech_ms_next  = 32'd0;
          sent_samples_next    = 32'd0;
          emit                 = 1'b1;
          kind_next            = vsg_pkg::KIND_END;
          session_next         = active_session;
          count_next           = sent_samples;
          cause_next           = length_hit ? vsg_pkg::CAUSE_LENGTH : vsg_pkg::CAUSE_SILENCE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= vsg_pkg::PH_IDLE;
      next_session    <= vsg_pkg::FIRST_SESSION;
      active_session  <= 32'd0;
      listen_start_ms <= 32'd0;
      last_speech_ms  <= 32'd0;
      sent_samples    <= 32'd0;
      out_valid       <= 1'b0;
    end else begin
      if (item_take) begin
        phase           <= phase_next;
        next_session    <= next_session_next;
        active_session  <= active_session_next;
        listen_start_ms <= listen_start_ms_next;
        last_speech_ms  <= last_speech_ms_next;
        sent_samples    <= sent_samples_next;
      end
      if (item_take && emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_kind    <= kind_next;
      out_session <= session_next;
      out_count   <= count_next;
      out_cause   <= cause_next;
      out_notice  <= notice_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.session_number = out_session;
  assign res.sample_count   = out_count;
  assign res.end_cause      = out_cause;
  assign res.notice         = out_notice;

endmodule
